FILE: design/bze_pkg.sv
`default_nettype none

package bze_pkg;

	localparam int CNT_W = 19;
	localparam int LEN_W = 19;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             is_last;
		logic [1:0]       status;
		logic [7:0]       code_version;
		logic [LEN_W-1:0] total_length;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SKIP,
		PH_HEADER,
		PH_COPY,
		PH_DONE
	} phase_t;

	localparam logic [1:0] ST_DATA     = 2'd0;
	localparam logic [1:0] ST_NOMARKER = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;

	localparam logic [7:0] CHAR_Z = 8'h5A;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_O = 8'h4F;
	localparam logic [7:0] CHAR_D = 8'h44;

	localparam logic [CNT_W-1:0] CNT_SKIP_LAST = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_VERSION   = CNT_W'(0);
	localparam logic [CNT_W-1:0] CNT_LEN_HI    = CNT_W'(26);
	localparam logic [CNT_W-1:0] CNT_LEN_LO    = CNT_W'(27);
	localparam logic [LEN_W-1:0] LEN_HDR       = LEN_W'(28);

	function automatic logic [7:0] marker_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = CHAR_Z;
			2'd1: c = CHAR_C;
			2'd2: c = CHAR_O;
			default: c = CHAR_D;
		endcase
		return c;
	endfunction

	// versions 1-3 scale by 2, 6-127 by 8, all others by 4
	function automatic logic [LEN_W-1:0] scale_length(input logic [7:0] ver,
			input logic [15:0] word);
		logic [LEN_W-1:0] w;
		w = LEN_W'(word);
		if (ver >= 8'd1 && ver <= 8'd3) begin
			return w << 1;
		end else if (ver >= 8'd6 && ver <= 8'd127) begin
			return w << 3;
		end else begin
			return w << 2;
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/bze_in_reg.sv
`default_nettype none

module bze_in_reg
	import bze_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire logic     adv,
	input  wire in_item_t d,
	output in_item_t      item_s1,
	output logic          valid_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: hold until the next transfer in
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= d;
		end
	end

endmodule

`default_nettype wire

FILE: design/bze_parse.sv
`default_nettype none

module bze_parse
	import bze_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire in_item_t item,
	output out_item_t     res,
	output logic          has_res,
	output logic          done
);

	phase_t           phase_q, phase_d;
	logic [1:0]       match_q, match_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       ver_q, ver_d;
	logic [7:0]       hi_q, hi_d;
	logic [LEN_W-1:0] len_q, len_d;

	logic [7:0] b;
	logic       eoi;

	assign b    = item.data_byte;
	assign eoi  = item.end_of_input;
	assign done = (phase_q == PH_DONE);

	// next state
	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		cnt_d   = cnt_q;
		ver_d   = ver_q;
		hi_d    = hi_q;
		len_d   = len_q;
		if (phase_q != PH_DONE) begin
			if (eoi) begin
				phase_d = PH_DONE;
			end else begin
				case (phase_q)
					PH_SEARCH: begin
						if (b == marker_char(match_q)) begin
							if (match_q == 2'd3) begin
								match_d = 2'd0;
								cnt_d   = '0;
								phase_d = PH_SKIP;
							end else begin
								match_d = match_q + 2'd1;
							end
						end else begin
							match_d = (b == CHAR_Z) ? 2'd1 : 2'd0;
						end
					end
					PH_SKIP: begin
						if (cnt_q == CNT_SKIP_LAST) begin
							cnt_d   = '0;
							phase_d = PH_HEADER;
						end else begin
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
					PH_HEADER: begin
						if (cnt_q == CNT_VERSION) begin
							ver_d = b;
						end
						if (cnt_q == CNT_LEN_HI) begin
							hi_d = b;
						end
						cnt_d = cnt_q + CNT_W'(1);
						if (cnt_q == CNT_LEN_LO) begin
							len_d   = scale_length(ver_q, {hi_q, b});
							phase_d = (len_d <= LEN_HDR) ? PH_DONE : PH_COPY;
						end
					end
					PH_COPY: begin
						cnt_d = cnt_q + CNT_W'(1);
						if (LEN_W'(cnt_d) >= len_q) begin
							phase_d = PH_DONE;
						end
					end
					default: begin
						phase_d = PH_DONE;
					end
				endcase
			end
		end
	end

	// result
	always_comb begin
		res.out_byte     = 8'd0;
		res.is_last      = 1'b0;
		res.status       = ST_DATA;
		res.code_version = ver_d;
		res.total_length = len_d;
		has_res          = 1'b0;
		if (phase_q != PH_DONE) begin
			if (eoi) begin
				has_res    = 1'b1;
				res.status = (phase_q == PH_SEARCH) ? ST_NOMARKER : ST_SHORT;
			end else if (phase_q == PH_HEADER || phase_q == PH_COPY) begin
				has_res      = 1'b1;
				res.out_byte = b;
				res.is_last  = (phase_d == PH_DONE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			match_q <= 2'd0;
			cnt_q   <= '0;
			ver_q   <= 8'd0;
			hi_q    <= 8'd0;
			len_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			match_q <= match_d;
			cnt_q   <= cnt_d;
			ver_q   <= ver_d;
			hi_q    <= hi_d;
			len_q   <= len_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/blorb_zcode_extractor_top.sv
// Code image extractor for a container byte stream.
// Input channel (byte_valid / byte_stall / byte_item): one container byte per
// transfer, or an end-of-input item. Output channel (code_valid / code_stall /
// code_item): extracted bytes with last flag, or a single error status.
// The block scans for the chunk marker, skips the four length bytes, emits the
// 28 header bytes and then the body until the scaled length is reached.
// Each result passes through two registers, the input register and then the
// result register, and is offered on code_valid from the result register.
// Throughput: one byte per cycle while code_stall is low; the limit is the
// single state update per byte in the parse stage.
// Bytes that give no result (search, skip) are consumed without output.
// A stalled receiver holds the result register; one more input byte is taken
// into the input register, then byte_stall rises until the output drains.
// Reset (arst_n low) clears both valid flags and returns to the marker search
// with version and length at zero. After the last byte or an error status the
// block accepts and drops all further input.
`default_nettype none

module blorb_zcode_extractor_top
	import bze_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_stall,
	input  wire in_item_t byte_item,
	output logic          code_valid,
	input  wire logic     code_stall,
	output out_item_t     code_item
);

	in_item_t  item_s1;
	logic      valid_s1;
	logic      load;
	logic      adv;
	out_item_t res;
	logic      has_res;
	logic      done;
	logic      code_valid_q;
	out_item_t code_item_q;

	// advance the input stage when the result register is free or draining
	assign adv        = valid_s1 && (!code_valid_q || !code_stall);
	assign byte_stall = valid_s1 && !adv;
	assign load       = byte_valid && !byte_stall;

	bze_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.adv      (adv),
		.d        (byte_item),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	bze_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item    (item_s1),
		.res     (res),
		.has_res (has_res),
		.done    (done)
	);

	// result register: load on advance, drop after the transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (adv) begin
			code_valid_q <= has_res;
		end else if (!code_stall) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_item_q <= res;
		end
	end

	assign code_valid = code_valid_q;
	assign code_item  = code_item_q;

`ifndef NO_ASSERTIONS
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |-> !has_res)
		else $error("result produced after extraction finished");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv && has_res && (res.is_last || res.status != ST_DATA) |=> done)
		else $error("parser not finished after last byte or error");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_item.status != ST_DATA
		|-> !code_item.is_last && code_item.out_byte == 8'd0)
		else $error("error result carries data");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !byte_stall)
		else $error("input stalled with empty input stage");
`endif

endmodule

`default_nettype wire
